### design/border_stability_filter_defines.svh
// Assertion macros for the border stability filter.
// Used by the top level; expects clk and arst_n in the enclosing scope.
`ifndef BORDER_STABILITY_FILTER_DEFINES_SVH
`define BORDER_STABILITY_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/bsf_pkg.sv
// Shared types and constants for the border stability filter.
// No dependencies; imported by every module of the block.
package bsf_pkg;

	localparam int SIZE_WIDTH     = 11;
	localparam int CFG_WIDTH      = 16;
	localparam int CFG_ADDR_WIDTH = 2;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_WIDTH-1:0] REG_UNKNOWN_SWITCH   = 2'd0;
	localparam logic [CFG_ADDR_WIDTH-1:0] REG_BORDER_SWITCH    = 2'd1;
	localparam logic [CFG_ADDR_WIDTH-1:0] REG_MAX_INCONSISTENT = 2'd2;

	// Configuration reset values.
	localparam logic [CFG_WIDTH-1:0] UNKNOWN_SWITCH_RESET   = 16'd600;
	localparam logic [CFG_WIDTH-1:0] BORDER_SWITCH_RESET    = 16'd50;
	localparam logic [CFG_WIDTH-1:0] MAX_INCONSISTENT_RESET = 16'd10;

	typedef struct packed {
		logic                  det_unknown;
		logic [SIZE_WIDTH-1:0] det_horizontal;
		logic [SIZE_WIDTH-1:0] det_vertical;
	} bsf_det_t;

	typedef struct packed {
		logic                  changed;
		logic                  cur_unknown;
		logic [SIZE_WIDTH-1:0] cur_horizontal;
		logic [SIZE_WIDTH-1:0] cur_vertical;
	} bsf_res_t;

	typedef struct packed {
		logic                  unk;
		logic [SIZE_WIDTH-1:0] hor;
		logic [SIZE_WIDTH-1:0] ver;
	} bsf_border_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] unknown_switch;
		logic [CFG_WIDTH-1:0] border_switch;
		logic [CFG_WIDTH-1:0] max_inconsistent;
	} bsf_cfg_t;

endpackage

### design/bsf_cfg_regs.sv
// Configuration register file of the border stability filter.
// Depends on bsf_pkg for the register indexes, reset values and bsf_cfg_t.
module bsf_cfg_regs
	import bsf_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
	input  logic [CFG_WIDTH-1:0]      cfg_data,
	output bsf_cfg_t                  cfg
);

	bsf_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unknown_switch   <= UNKNOWN_SWITCH_RESET;
			cfg_q.border_switch    <= BORDER_SWITCH_RESET;
			cfg_q.max_inconsistent <= MAX_INCONSISTENT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_UNKNOWN_SWITCH:   cfg_q.unknown_switch   <= cfg_data;
				REG_BORDER_SWITCH:    cfg_q.border_switch    <= cfg_data;
				REG_MAX_INCONSISTENT: cfg_q.max_inconsistent <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/bsf_next.sv
// Next-state and result logic of the border stability filter.
// Depends on bsf_pkg; purely combinational, evaluated once per item.
module bsf_next
	import bsf_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  bsf_det_t               det,
	input  bsf_cfg_t               cfg,
	input  bsf_border_t            cand,
	input  bsf_border_t            applied,
	input  logic [COUNT_WIDTH-1:0] cons_cnt,
	input  logic [COUNT_WIDTH-1:0] incons_cnt,
	output bsf_border_t            cand_nxt,
	output bsf_border_t            applied_nxt,
	output logic [COUNT_WIDTH-1:0] cons_cnt_nxt,
	output logic [COUNT_WIDTH-1:0] incons_cnt_nxt,
	output logic                   changed
);

	localparam int CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	function automatic logic border_eq(bsf_border_t a, bsf_border_t b);
		border_eq = (a.unk && b.unk) ||
			(a.unk == b.unk && a.hor == b.hor && a.ver == b.ver);
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(logic [COUNT_WIDTH-1:0] v);
		sat_inc = (v == CNT_MAX) ? CNT_MAX : v + COUNT_WIDTH'(1);
	endfunction

	bsf_border_t det_b;
	logic        proceed;

	// Sizes of an unknown detection are forced to zero before anything is stored.
	always_comb begin
		det_b.unk = det.det_unknown;
		det_b.hor = det.det_unknown ? '0 : det.det_horizontal;
		det_b.ver = det.det_unknown ? '0 : det.det_vertical;
	end

	always_comb begin
		cand_nxt       = cand;
		applied_nxt    = applied;
		cons_cnt_nxt   = cons_cnt;
		incons_cnt_nxt = incons_cnt;
		changed        = 1'b0;
		proceed        = 1'b1;

		if (border_eq(det_b, cand)) begin
			cons_cnt_nxt   = sat_inc(cons_cnt);
			incons_cnt_nxt = '0;
		end else begin
			incons_cnt_nxt = sat_inc(incons_cnt);
			if (CMP_W'(incons_cnt_nxt) <= CMP_W'(cfg.max_inconsistent)) begin
				// Still within tolerance: this frame is ignored.
				proceed = 1'b0;
			end else begin
				cand_nxt     = det_b;
				cons_cnt_nxt = '0;
			end
		end

		if (proceed) begin
			priority if (border_eq(applied, det_b)) begin
				incons_cnt_nxt = '0;
			end else if (det_b.unk) begin
				if (CMP_W'(cons_cnt_nxt) == CMP_W'(cfg.unknown_switch)) begin
					applied_nxt = det_b;
					changed     = 1'b1;
				end
			end else begin
				if (applied.unk || CMP_W'(cons_cnt_nxt) == CMP_W'(cfg.border_switch)) begin
					applied_nxt = det_b;
					changed     = 1'b1;
				end
			end
		end
	end

endmodule

### design/border_stability_filter.sv
// Top level of the border stability filter: input register, state, result register.
// Depends on bsf_pkg, bsf_cfg_regs, bsf_next and border_stability_filter_defines.svh.
//
//   channel   signals                          payload
//   det       det_valid / det_ready / det      bsf_det_t, one detected border per frame
//   res       res_valid / res_ready / res      bsf_res_t, changed flag and applied border
//   cfg       cfg_we / cfg_addr / cfg_data     write-only register port, no wait
//
// One item is accepted per cycle when the result side keeps up. An accepted item sits
// in the input register, where the decision logic reads the filter state; the state
// and the result register are written when the item advances, once the result register
// is free or being drained, and the result is then offered from the result register.
// The rate is set by the state update loop, which closes through the decision logic.
// Reset returns the candidate and applied borders to unknown and the counters to their
// initial values. While a result waits with res_ready low, the result register holds
// and the input register holds its item, so at most two items are in flight.
`include "border_stability_filter_defines.svh"

module border_stability_filter
	import bsf_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      det_valid,
	output logic                      det_ready,
	input  bsf_det_t                  det,
	output logic                      res_valid,
	input  logic                      res_ready,
	output bsf_res_t                  res,
	input  logic                      cfg_we,
	input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
	input  logic [CFG_WIDTH-1:0]      cfg_data
);

	// Initial inconsistent count, held to the counter width.
	localparam logic [COUNT_WIDTH-1:0] INCONS_RESET = COUNT_WIDTH'(10);

	bsf_cfg_t cfg;

	// Input register: holds an accepted item until its state update happens.
	logic     det_valid_s1;
	bsf_det_t det_s1;

	// Filter state.
	bsf_border_t            cand_q;
	bsf_border_t            applied_q;
	logic [COUNT_WIDTH-1:0] cons_cnt_q;
	logic [COUNT_WIDTH-1:0] incons_cnt_q;

	// Result register.
	logic     res_valid_s2;
	bsf_res_t res_s2;

	bsf_border_t            cand_nxt;
	bsf_border_t            applied_nxt;
	logic [COUNT_WIDTH-1:0] cons_cnt_nxt;
	logic [COUNT_WIDTH-1:0] incons_cnt_nxt;
	logic                   changed_nxt;
	logic                   advance;

	bsf_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	bsf_next #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_next (
		.det            (det_s1),
		.cfg            (cfg),
		.cand           (cand_q),
		.applied        (applied_q),
		.cons_cnt       (cons_cnt_q),
		.incons_cnt     (incons_cnt_q),
		.cand_nxt       (cand_nxt),
		.applied_nxt    (applied_nxt),
		.cons_cnt_nxt   (cons_cnt_nxt),
		.incons_cnt_nxt (incons_cnt_nxt),
		.changed        (changed_nxt)
	);

	// The held item is processed whenever the result register is free or being drained.
	assign advance   = det_valid_s1 && (!res_valid_s2 || res_ready);
	assign det_ready = !det_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_valid_s1 <= 1'b0;
		end else if (det_ready) begin
			det_valid_s1 <= det_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (det_ready && det_valid) begin
			det_s1 <= det;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q       <= '{unk: 1'b1, hor: '0, ver: '0};
			applied_q    <= '{unk: 1'b1, hor: '0, ver: '0};
			cons_cnt_q   <= '0;
			incons_cnt_q <= INCONS_RESET;
		end else if (advance) begin
			cand_q       <= cand_nxt;
			applied_q    <= applied_nxt;
			cons_cnt_q   <= cons_cnt_nxt;
			incons_cnt_q <= incons_cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (res_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	// The result always reports the applied border after this frame's update.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2.changed        <= changed_nxt;
			res_s2.cur_unknown    <= applied_nxt.unk;
			res_s2.cur_horizontal <= applied_nxt.hor;
			res_s2.cur_vertical   <= applied_nxt.ver;
		end
	end

	assign res_valid = res_valid_s2;
	assign res       = res_s2;

	// An unknown applied border never carries sizes.
	`BSF_ASSERT_NOW(a_unknown_zero_size, res_valid && res.cur_unknown, res.cur_horizontal == '0 && res.cur_vertical == '0, "unknown border reported with nonzero size")

	// The applied border moves only on an item that reports a change.
	`BSF_ASSERT_NEXT(a_applied_stable, !(advance && changed_nxt), $stable(applied_q), "applied border changed without a reported change")

	// A held item is never dropped while the result side stalls.
	`BSF_ASSERT_NEXT(a_hold_item, det_valid_s1 && !advance, det_valid_s1 && $stable(det_s1), "held item lost during stall")

	// A reported change always carries a border that differs from the one before it.
	`BSF_ASSERT_NEXT(a_change_differs, advance && changed_nxt, applied_q != $past(applied_q), "change reported with same border")

endmodule

### dv/border_stability_filter_tb.sv
// Self-checking testbench for the border stability filter: directed frames, random runs
// of repeated borders with noise, and two runs with a threshold at its maximum.
// Depends on bsf_pkg and border_stability_filter; nothing else.
module border_stability_filter_tb;
	import bsf_pkg::*;

	// Counter width of the block as instantiated; the filter state mirrors it.
	localparam int CNT_W = 16;
	// Index 3 decodes to no register, so a write there must leave the settings alone.
	localparam logic [CFG_ADDR_WIDTH-1:0] REG_UNUSED = 2'd3;
	// A correct run ends well before this limit; reaching it counts as a failure.
	localparam int CYCLE_LIMIT = 100_000;
	// Cycles waited after the last expected result is checked, so everything settles.
	localparam int DRAIN_CYCLES = 8;
	localparam int SOAK_FRAMES = 50;
	localparam int RUN_FRAMES = 120;

	typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic det_valid = 1'b0;
	logic det_ready;
	bsf_det_t det = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	bsf_res_t res;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_WIDTH-1:0] cfg_addr = '0;
	logic [CFG_WIDTH-1:0] cfg_data = '0;

	border_stability_filter #(.COUNT_WIDTH(CNT_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.det_valid(det_valid),
		.det_ready(det_ready),
		.det(det),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Frames waiting to be offered, and the results the filter state says must come back.
	bsf_det_t pending_frames[$];
	bsf_res_t expected_borders[$];

	// Mirror of the filter: candidate and applied borders, the two frame counters and the
	// three thresholds as last written.
	bsf_border_t cand_border;
	bsf_border_t shown_border;
	logic [CNT_W-1:0] steady_frames;
	logic [CNT_W-1:0] unsteady_frames;
	logic [CFG_WIDTH-1:0] unknown_after;
	logic [CFG_WIDTH-1:0] known_after;
	logic [CFG_WIDTH-1:0] noise_allowed;

	int cycle_count = 0;
	int frames_launched = 0;
	int frames_accepted = 0;
	int results_checked = 0;
	int border_switches = 0;
	int unknown_switches = 0;
	int input_stall_cycles = 0;
	int failures = 0;

	bsf_det_t border_pool[4];

	task automatic reset_filter_model();
		cand_border = '{unk: 1'b1, hor: '0, ver: '0};
		shown_border = cand_border;
		steady_frames = '0;
		unsteady_frames = CNT_W'(MAX_INCONSISTENT_RESET);
		unknown_after = UNKNOWN_SWITCH_RESET;
		known_after = BORDER_SWITCH_RESET;
		noise_allowed = MAX_INCONSISTENT_RESET;
	endtask

	// Two unknown borders match whatever their sizes; unknown sizes are stored as zero,
	// so in every other case a plain compare of all three fields decides.
	function automatic logic same_border(bsf_border_t a, bsf_border_t b);
		if (a.unk && b.unk)
			return 1'b1;
		return a == b;
	endfunction

	function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Advances the filter by one detected frame and returns the result it must report.
	function automatic bsf_res_t debounce_border(bsf_det_t d);
		bsf_border_t seen;
		bsf_res_t r;
		logic flip;
		logic ignored;
		seen.unk = d.det_unknown;
		seen.hor = d.det_unknown ? '0 : d.det_horizontal;
		seen.ver = d.det_unknown ? '0 : d.det_vertical;
		flip = 1'b0;
		ignored = 1'b0;
		if (same_border(seen, cand_border)) begin
			steady_frames = bump(steady_frames);
			unsteady_frames = '0;
		end else begin
			unsteady_frames = bump(unsteady_frames);
			if (unsteady_frames <= noise_allowed) begin
				ignored = 1'b1;
			end else begin
				cand_border = seen;
				steady_frames = '0;
			end
		end
		if (!ignored) begin
			if (same_border(shown_border, seen)) begin
				unsteady_frames = '0;
			end else if (seen.unk) begin
				if (steady_frames == unknown_after) begin
					shown_border = seen;
					flip = 1'b1;
				end
			end else if (shown_border.unk || steady_frames == known_after) begin
				shown_border = seen;
				flip = 1'b1;
			end
		end
		r.changed = flip;
		r.cur_unknown = shown_border.unk;
		r.cur_horizontal = shown_border.hor;
		r.cur_vertical = shown_border.ver;
		return r;
	endfunction

	task automatic note_failure(string what);
		failures++;
		if (failures <= 10)
			$display("[%0d] MISMATCH %s", cycle_count, what);
	endtask

	// Monitor: everything is sampled on the rising edge, where the handshakes complete.
	// Register writes update the mirrored thresholds, accepted frames run through the
	// filter model, and accepted results are checked against the oldest expectation.
	bsf_res_t want;
	always @(posedge clk) begin
		cycle_count++;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_UNKNOWN_SWITCH: unknown_after = cfg_data;
					REG_BORDER_SWITCH: known_after = cfg_data;
					REG_MAX_INCONSISTENT: noise_allowed = cfg_data;
					default: ;
				endcase
			end
			if (det_valid && !det_ready)
				input_stall_cycles++;
			if (det_valid && det_ready) begin
				expected_borders.push_back(debounce_border(det));
				frames_accepted++;
			end
			if (res_valid && res_ready) begin
				results_checked++;
				if (res.changed)
					border_switches++;
				if (res.changed && res.cur_unknown)
					unknown_switches++;
				if (expected_borders.size() == 0) begin
					note_failure($sformatf("result with nothing pending: chg=%0b unk=%0b h=%0d v=%0d",
						res.changed, res.cur_unknown, res.cur_horizontal, res.cur_vertical));
				end else begin
					want = expected_borders.pop_front();
					if (res.changed !== want.changed || res.cur_unknown !== want.cur_unknown ||
							res.cur_horizontal !== want.cur_horizontal ||
							res.cur_vertical !== want.cur_vertical)
						note_failure($sformatf(
							"exp chg=%0b unk=%0b h=%0d v=%0d, got chg=%0b unk=%0b h=%0d v=%0d",
							want.changed, want.cur_unknown, want.cur_horizontal, want.cur_vertical,
							res.changed, res.cur_unknown, res.cur_horizontal, res.cur_vertical));
				end
			end
		end
	end

	// Driver: works in bursts of random length separated by random gaps. About a third of
	// the bursts are followed by no gap at all, so long back-to-back stretches also occur.
	// A frame stays on the bus until the monitor has counted it as accepted.
	int burst_left = 1;
	int gap_left = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			det_valid <= 1'b0;
		end else if (frames_accepted == frames_launched) begin
			if (gap_left > 0) begin
				gap_left--;
				det_valid <= 1'b0;
			end else if (pending_frames.size() != 0) begin
				det <= pending_frames.pop_front();
				det_valid <= 1'b1;
				frames_launched++;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				det_valid <= 1'b0;
			end
		end
	end

	// Receiver: picks a new stall pattern at random at regular intervals. Once per longer
	// period, at the first moment plenty of frames are still queued, it holds off for a long
	// stretch while the driver keeps offering frames, so both internal registers fill and
	// det_ready has to drop.
	rx_mode_t rx_mode = RX_STREAM;
	int rx_cycles = 0;
	int hold_left = 0;
	logic hold_due = 1'b1;
	logic take;
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			rx_cycles++;
			if (rx_cycles % 64 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			if (rx_cycles % 1024 == 300)
				hold_due = 1'b1;
			if (hold_due && hold_left == 0 && pending_frames.size() > 32) begin
				hold_due = 1'b0;
				hold_left = 64 + $urandom_range(0, 32);
			end
			if (hold_left > 0) begin
				hold_left--;
				take = 1'b0;
			end else begin
				case (rx_mode)
					RX_STREAM: take = 1'b1;
					RX_COIN: take = 1'($urandom_range(0, 1));
					RX_SPARSE: take = ($urandom_range(0, 3) == 0);
					default: take = (rx_cycles % 4 != 0);
				endcase
			end
			res_ready <= take;
		end
	end

	task automatic queue_frame(logic unk, logic [SIZE_WIDTH-1:0] hor, logic [SIZE_WIDTH-1:0] ver);
		pending_frames.push_back(bsf_det_t'{det_unknown: unk, det_horizontal: hor,
			det_vertical: ver});
	endtask

	function automatic bsf_det_t any_frame(logic unk);
		bsf_det_t f;
		f.det_unknown = unk;
		f.det_horizontal = SIZE_WIDTH'($urandom_range(0, (1 << SIZE_WIDTH) - 1));
		f.det_vertical = SIZE_WIDTH'($urandom_range(0, (1 << SIZE_WIDTH) - 1));
		return f;
	endfunction

	// Register writes happen only while the block is idle.
	task automatic write_reg(logic [CFG_ADDR_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_thresholds(logic [CFG_WIDTH-1:0] unk_cnt, logic [CFG_WIDTH-1:0] known_cnt,
			logic [CFG_WIDTH-1:0] noise_cnt);
		write_reg(REG_UNKNOWN_SWITCH, unk_cnt);
		write_reg(REG_BORDER_SWITCH, known_cnt);
		write_reg(REG_MAX_INCONSISTENT, noise_cnt);
	endtask

	task automatic wait_drained();
		while (pending_frames.size() != 0 || frames_accepted != frames_launched ||
				expected_borders.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Well-formed traffic: runs of one border, known or unknown, with the odd stray frame.
	// Known borders mostly come from a small pool so that borders recur and the switch
	// thresholds are actually reached; unknown frames carry random sizes that must be
	// ignored.
	task automatic queue_border_runs(int count);
		bsf_det_t run_border;
		int run_len;
		int pick;
		while (count > 0) begin
			pick = $urandom_range(0, 9);
			if (pick < 3)
				run_border = any_frame(1'b1);
			else if (pick < 8)
				run_border = border_pool[2'($urandom_range(0, 3))];
			else
				run_border = any_frame(1'b0);
			run_len = $urandom_range(1, 12);
			for (int i = 0; i < run_len && count > 0; i++) begin
				if ($urandom_range(0, 9) == 0)
					pending_frames.push_back(any_frame(1'($urandom_range(0, 1))));
				else if (run_border.det_unknown)
					pending_frames.push_back(any_frame(1'b1));
				else
					pending_frames.push_back(run_border);
				count--;
			end
		end
	endtask

	initial begin
		reset_filter_model();
		foreach (border_pool[i])
			border_pool[i] = any_frame(1'b0);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset thresholds. The first known border is applied at once because the
		// applied border starts unknown; differing frames after that are only noise.
		queue_frame(1'b0, '1, '1);
		queue_frame(1'b0, '1, '1);
		queue_frame(1'b1, '1, '1);
		queue_frame(1'b0, '0, '0);
		queue_frame(1'b0, '1, '0);
		queue_frame(1'b0, '0, '1);
		queue_frame(1'b0, '1, '1);
		wait_drained();

		// Tight thresholds: a new known border after one steady frame, unknown after two,
		// and no tolerance for differing frames. A write to the unused index must not
		// disturb any of them.
		set_thresholds(16'd2, 16'd1, 16'd0);
		write_reg(REG_UNUSED, '1);
		queue_frame(1'b0, 11'd5, 11'd7);
		queue_frame(1'b0, 11'd5, 11'd7);
		queue_frame(1'b1, 11'd123, 11'd456);
		queue_frame(1'b1, '0, '0);
		queue_frame(1'b1, '1, '1);
		queue_frame(1'b1, 11'd1, 11'd1);
		queue_frame(1'b0, 11'd1024, 11'd1);
		queue_frame(1'b0, 11'd1024, 11'd1);
		queue_frame(1'b0, 11'd1023, 11'd2046);
		queue_frame(1'b0, 11'd1024, 11'd1);
		queue_frame(1'b0, 11'd1023, 11'd2046);
		queue_frame(1'b0, 11'd1023, 11'd2046);
		wait_drained();

		// Random runs under several threshold settings, from all zero to near the top.
		set_thresholds(16'd3, 16'd2, 16'd1);
		queue_border_runs(RUN_FRAMES);
		wait_drained();
		set_thresholds(16'd0, 16'd0, 16'd0);
		queue_border_runs(RUN_FRAMES);
		wait_drained();
		set_thresholds(CFG_WIDTH'($urandom_range(0, 10)), CFG_WIDTH'($urandom_range(0, 6)),
			CFG_WIDTH'($urandom_range(0, 4)));
		queue_border_runs(RUN_FRAMES);
		wait_drained();
		set_thresholds(16'd65534, 16'd65534, 16'd3);
		queue_border_runs(RUN_FRAMES);
		wait_drained();

		// Unknown threshold at its maximum: settle on a known border, then feed unknown
		// frames; the steady count stays far below the threshold, so no switch to unknown.
		set_thresholds(16'hFFFF, 16'd1, 16'd0);
		queue_frame(1'b0, 11'd9, 11'd9);
		queue_frame(1'b0, 11'd9, 11'd9);
		for (int i = 0; i < SOAK_FRAMES; i++)
			pending_frames.push_back(any_frame(1'b1));
		wait_drained();

		// Tolerance at its maximum: the differing-frame count can never exceed it, so the
		// candidate never changes, however many known borders arrive.
		set_thresholds(16'd0, 16'd0, 16'hFFFF);
		for (int i = 0; i < SOAK_FRAMES; i++)
			pending_frames.push_back(any_frame(1'b0));
		wait_drained();

		$display("Checked %0d results from %0d frames; %0d border switches, %0d of them to unknown.",
			results_checked, frames_accepted, border_switches, unknown_switches);
		$display("Input was held off for %0d cycles; %0d mismatches.", input_stall_cycles, failures);
		if (failures == 0 && expected_borders.size() == 0)
			$display("border_stability_filter regression: pass");
		else
			$display("border_stability_filter regression: fail");
		$finish;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("Timed out after %0d cycles with %0d results outstanding.",
			cycle_count, expected_borders.size());
		$display("border_stability_filter regression: fail");
		$finish;
	end

endmodule
